// ===== rtl/core/ise_pkg.sv =====
// Shared constants and types for the interval set engine.
package ise_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int BOUND_BITS_DEF  = 64;
    localparam int REQ_W           = 2;
    localparam int RANGE_W         = 64;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 6;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [RANGE_W-1:0] range_lo;
        logic [RANGE_W-1:0] range_hi;
    } req_t;

    typedef struct packed {
        logic                covered;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

// ===== rtl/core/ise_req_if.sv =====
// Valid/ready channel carrying one interval request.
interface ise_req_if;
    logic          valid;
    logic          ready;
    ise_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ise_rsp_if.sv =====
// Valid/ready channel carrying one interval response.
interface ise_rsp_if;
    logic          valid;
    logic          ready;
    ise_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/interval_set_engine_unit.sv =====
// Interval set engine: sorted disjoint interval table with a sequencer.
//
// Each add, remove or query walks the table one entry at a time: a scan
// reads one entry and then compares it, for an add or remove through the
// shared key comparator to find the affected span, for a query against
// both bounds directly; for an add or remove a move pass then shifts the
// tail of the table one entry at a time. An invalid or unknown request goes
// straight to the response. The block takes no new request until the
// response of the previous one has been transferred.
module interval_set_engine_unit #(
    parameter int TABLE_DEPTH = ise_pkg::TABLE_DEPTH_DEF,
    parameter int BOUND_BITS  = ise_pkg::BOUND_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ise_req_if.sink   req,
    ise_rsp_if.source rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = BOUND_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_I, S_SCAN_I, S_RD_J, S_SCAN_J, S_PLAN, S_CHECK, S_MV_RD, S_MV_WR,
        S_WR0, S_WR1, S_RESP
    } state_t;

    state_t state_reg;
    logic [KW-1:0] mem_lo [TABLE_DEPTH];
    logic [KW-1:0] mem_hi [TABLE_DEPTH];
    logic [KW-1:0] rd_lo_reg, rd_hi_reg;
    logic [KW-1:0] lo_reg, hi_reg, nlo_reg, nhi_reg, plo1_reg, phi1_reg;
    logic [KW-1:0] plo0_reg, phi0_reg;
    logic [ise_pkg::REQ_W-1:0] type_reg;
    logic [CW-1:0] n_reg, i_reg, j_reg, k_reg, newn_reg;
    logic [1:0] r_reg;
    logic covered_reg, commit_reg;
    logic [ise_pkg::STATUS_W-1:0] status_reg;
    logic [KW-1:0] first_lo_reg;
    logic rsp_valid_reg;

    // Keys: low BOUND_BITS bits with sign bit flipped, unsigned order
    logic [KW-1:0] key_lo, key_hi;
    assign key_lo = {~req.payload.range_lo[KW-1], req.payload.range_lo[KW-2:0]};
    assign key_hi = {~req.payload.range_hi[KW-1], req.payload.range_hi[KW-2:0]};

    // Shared compare unit
    logic [KW-1:0] cmp_a, cmp_b;
    logic cmp_lt, cmp_eq;
    always_comb
    begin
        cmp_a = rd_hi_reg;
        cmp_b = lo_reg;
        unique case (state_reg)
            S_SCAN_J: begin cmp_a = hi_reg; cmp_b = rd_lo_reg; end
            default:  begin cmp_a = rd_hi_reg; cmp_b = lo_reg; end
        endcase
    end
    assign cmp_lt = cmp_a < cmp_b;
    assign cmp_eq = (cmp_a + KW'(1)) == cmp_b;

    // Scan conditions (adjacency without wrap: a+1==b with a<b)
    logic adv_i, adv_j;
    always_comb
    begin
        if (type_reg == ise_pkg::REQ_ADD) begin
            adv_i = cmp_lt && !cmp_eq;
            adv_j = !(cmp_lt && !cmp_eq);
        end else begin
            adv_i = cmp_lt;
            adv_j = !cmp_lt;
        end
    end

    // Tail move bookkeeping: src index and destination index
    logic [CW-1:0] dst_base;
    logic [CW:0] newn_calc;
    assign dst_base  = i_reg + CW'(r_reg);
    assign newn_calc = {1'b0, n_reg} - ({1'b0, j_reg} - {1'b0, i_reg}) + (CW+1)'(r_reg);
    logic grow;
    assign grow = (dst_base > j_reg);

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload.covered = covered_reg;
    assign rsp.payload.status = status_reg;
    assign rsp.payload.entry_count = ise_pkg::COUNT_W'(n_reg);

    logic [AW-1:0] rd_addr;
    logic rd_en;
    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            S_RD_I:  begin rd_en = 1'b1; rd_addr = i_reg[AW-1:0]; end
            S_RD_J:  begin rd_en = 1'b1; rd_addr = j_reg[AW-1:0]; end
            S_MV_RD: begin rd_en = 1'b1; rd_addr = k_reg[AW-1:0]; end
            default: begin rd_en = 1'b0; rd_addr = '0; end
        endcase
    end

    // Table memory: one read port, one write port, registered read data
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_lo, wr_hi;
    logic [CW-1:0] mv_dst;
    assign mv_dst = grow ? (k_reg + (dst_base - j_reg)) : (k_reg - (j_reg - dst_base));
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = '0;
        wr_lo = nlo_reg;
        wr_hi = nhi_reg;
        unique case (state_reg)
            S_MV_WR: begin wr_en = 1'b1; wr_addr = mv_dst[AW-1:0];
                wr_lo = rd_lo_reg; wr_hi = rd_hi_reg; end
            S_WR0: begin wr_en = (r_reg != 2'd0); wr_addr = i_reg[AW-1:0];
                wr_lo = plo0_reg; wr_hi = phi0_reg; end
            S_WR1: begin wr_en = 1'b1; wr_addr = AW'(i_reg + CW'(1));
                wr_lo = plo1_reg; wr_hi = phi1_reg; end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_lo[wr_addr] <= wr_lo;
            mem_hi[wr_addr] <= wr_hi;
        end
        if (rd_en) begin
            rd_lo_reg <= mem_lo[rd_addr];
            rd_hi_reg <= mem_hi[rd_addr];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            n_reg <= '0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0; r_reg <= '0; newn_reg <= '0;
            type_reg <= '0; covered_reg <= 1'b0; status_reg <= ise_pkg::ST_OK;
            commit_reg <= 1'b0;
            lo_reg <= '0; hi_reg <= '0; nlo_reg <= '0; nhi_reg <= '0;
            plo0_reg <= '0; phi0_reg <= '0; plo1_reg <= '0; phi1_reg <= '0;
            first_lo_reg <= '0;
        end else begin
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (req.valid && req.ready) begin
                        type_reg <= req.payload.req_type;
                        lo_reg <= key_lo;
                        hi_reg <= key_hi;
                        nlo_reg <= key_lo;
                        nhi_reg <= key_hi;
                        covered_reg <= 1'b0;
                        status_reg <= ise_pkg::ST_OK;
                        commit_reg <= 1'b0;
                        i_reg <= '0;
                        r_reg <= '0;
                        if (req.payload.req_type == ise_pkg::REQ_NONE)
                            state_reg <= S_RESP;
                        else if (key_lo > key_hi) begin
                            status_reg <= ise_pkg::ST_INVALID;
                            state_reg <= S_RESP;
                        end else
                            state_reg <= S_RD_I;
                    end
                end
                S_RD_I: begin
                    if (i_reg >= n_reg) begin
                        j_reg <= i_reg;
                        state_reg <= (type_reg == ise_pkg::REQ_QUERY) ? S_RESP : S_RD_J;
                    end else
                        state_reg <= S_SCAN_I;
                end
                S_SCAN_I: begin
                    if (type_reg == ise_pkg::REQ_QUERY) begin
                        // Covered when entry lo <= lo and entry hi >= hi
                        if (rd_lo_reg <= lo_reg && rd_hi_reg >= hi_reg) begin
                            covered_reg <= 1'b1;
                            state_reg <= S_RESP;
                        end else begin
                            i_reg <= i_reg + CW'(1);
                            state_reg <= S_RD_I;
                        end
                    end else if (adv_i) begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_RD_I;
                    end else begin
                        first_lo_reg <= rd_lo_reg;
                        j_reg <= i_reg;
                        state_reg <= S_RD_J;
                    end
                end
                S_RD_J: begin
                    if (j_reg >= n_reg)
                        state_reg <= S_PLAN;
                    else
                        state_reg <= S_SCAN_J;
                end
                S_SCAN_J: begin
                    if (adv_j) begin
                        j_reg <= j_reg + CW'(1);
                        nhi_reg <= rd_hi_reg;
                        state_reg <= S_RD_J;
                    end else
                        state_reg <= S_PLAN;
                end
                S_PLAN: begin
                    // Work out the replacement entries
                    if (type_reg == ise_pkg::REQ_ADD) begin
                        plo0_reg <= (j_reg > i_reg && first_lo_reg < lo_reg)
                                    ? first_lo_reg : lo_reg;
                        phi0_reg <= (j_reg > i_reg && nhi_reg > hi_reg) ? nhi_reg : hi_reg;
                        r_reg <= 2'd1;
                        state_reg <= S_CHECK;
                    end else if (j_reg == i_reg)
                        state_reg <= S_RESP;
                    else begin
                        if (first_lo_reg < lo_reg) begin
                            plo0_reg <= first_lo_reg;
                            phi0_reg <= lo_reg - KW'(1);
                            plo1_reg <= hi_reg + KW'(1);
                            phi1_reg <= nhi_reg;
                        end else begin
                            plo0_reg <= hi_reg + KW'(1);
                            phi0_reg <= nhi_reg;
                        end
                        r_reg <= 2'(first_lo_reg < lo_reg) + 2'(nhi_reg > hi_reg);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // Drop the request when the table would overflow
                    if (newn_calc > (CW+1)'(TABLE_DEPTH)) begin
                        status_reg <= ise_pkg::ST_FULL;
                        state_reg <= S_RESP;
                    end else begin
                        commit_reg <= 1'b1;
                        newn_reg <= CW'(newn_calc);
                        k_reg <= grow ? n_reg - CW'(1) : j_reg;
                        state_reg <= (j_reg >= n_reg) ? S_WR0 : S_MV_RD;
                    end
                end
                S_MV_RD: state_reg <= S_MV_WR;
                S_MV_WR: begin
                    if (grow) begin
                        if (k_reg == j_reg)
                            state_reg <= S_WR0;
                        else begin
                            k_reg <= k_reg - CW'(1);
                            state_reg <= S_MV_RD;
                        end
                    end else begin
                        if (k_reg + CW'(1) >= n_reg)
                            state_reg <= S_WR0;
                        else begin
                            k_reg <= k_reg + CW'(1);
                            state_reg <= S_MV_RD;
                        end
                    end
                end
                S_WR0: state_reg <= (r_reg == 2'd2) ? S_WR1 : S_RESP;
                S_WR1: state_reg <= S_RESP;
                S_RESP: begin
                    if (commit_reg)
                        n_reg <= newn_reg;
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(TABLE_DEPTH)) else $error("entry count above depth");
    // No request is taken while a response is pending
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !req.ready) else $error("accept while response pending");
    // Covered is only reported for queries
    a_covered_query: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && covered_reg) |-> type_reg == ise_pkg::REQ_QUERY)
        else $error("covered on non-query");

endmodule

// ===== verif/interval_set_engine_unit_tb.sv =====
// Testbench for the interval set engine: predicts every response and checks it.
module interval_set_engine_unit_tb;

    localparam int DEPTH     = ise_pkg::TABLE_DEPTH_DEF;
    localparam int WDOG_MAX  = 20000;
    localparam logic [63:0] FLIP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ise_req_if req_ch();
    ise_rsp_if rsp_ch();

    interval_set_engine_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #4 clk = ~clk;

    // Shadow copy of the table, held as offset keys
    logic [63:0] tbl_lo [DEPTH];
    logic [63:0] tbl_hi [DEPTH];
    int          tbl_n;

    ise_pkg::rsp_t pending_rsp [$];
    int   fail_cnt;
    int   sent_cnt;
    int   got_cnt;
    int   idle_src_pct;
    int   stall_rcv_pct;
    int   quiet_cycles = 0;
    int   ok_cnt;
    int   full_cnt;
    int   inval_cnt;

    // Rewrite the table slice [i,j) with up to two new entries
    function automatic void splice(int i, int j, int r, logic [63:0] l0, logic [63:0] h0,
                                   logic [63:0] l1, logic [63:0] h1);
        logic [63:0] nl [DEPTH];
        logic [63:0] nh [DEPTH];
        int k;
        int m;
        m = 0;
        for (k = 0; k < i; k++)
        begin
            nl[m] = tbl_lo[k]; nh[m] = tbl_hi[k]; m++;
        end
        if (r > 0)
        begin
            nl[m] = l0; nh[m] = h0; m++;
        end
        if (r > 1)
        begin
            nl[m] = l1; nh[m] = h1; m++;
        end
        for (k = j; k < tbl_n; k++)
        begin
            nl[m] = tbl_lo[k]; nh[m] = tbl_hi[k]; m++;
        end
        for (k = 0; k < m; k++)
        begin
            tbl_lo[k] = nl[k]; tbl_hi[k] = nh[k];
        end
        tbl_n = m;
    endfunction

    // Compute the response of one request and update the shadow table
    function automatic ise_pkg::rsp_t predict_interval_op(ise_pkg::req_t rq);
        ise_pkg::rsp_t rs;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] nlo;
        logic [63:0] nhi;
        int i;
        int j;
        int r;
        int k;
        logic [63:0] pl [2];
        logic [63:0] ph [2];
        lo = rq.range_lo ^ FLIP;
        hi = rq.range_hi ^ FLIP;
        rs.covered = 1'b0;
        rs.status = ise_pkg::ST_OK;
        if (rq.req_type != ise_pkg::REQ_NONE && lo > hi)
            rs.status = ise_pkg::ST_INVALID;
        else if (rq.req_type == ise_pkg::REQ_ADD)
        begin
            i = 0;
            while (i < tbl_n && tbl_hi[i] < lo && ({1'b0, tbl_hi[i]} + 65'd1) != {1'b0, lo})
                i++;
            j = i;
            while (j < tbl_n && !(tbl_lo[j] > hi && ({1'b0, hi} + 65'd1) != {1'b0, tbl_lo[j]}))
                j++;
            nlo = lo;
            nhi = hi;
            if (j > i)
            begin
                if (tbl_lo[i] < nlo) nlo = tbl_lo[i];
                if (tbl_hi[j-1] > nhi) nhi = tbl_hi[j-1];
            end
            if (tbl_n - (j - i) + 1 > DEPTH)
                rs.status = ise_pkg::ST_FULL;
            else
                splice(i, j, 1, nlo, nhi, 64'd0, 64'd0);
        end
        else if (rq.req_type == ise_pkg::REQ_REMOVE)
        begin
            i = 0;
            while (i < tbl_n && tbl_hi[i] < lo)
                i++;
            j = i;
            while (j < tbl_n && tbl_lo[j] <= hi)
                j++;
            if (j > i)
            begin
                r = 0;
                if (tbl_lo[i] < lo)
                begin
                    pl[r] = tbl_lo[i]; ph[r] = lo - 64'd1; r++;
                end
                if (tbl_hi[j-1] > hi)
                begin
                    pl[r] = hi + 64'd1; ph[r] = tbl_hi[j-1]; r++;
                end
                if (tbl_n - (j - i) + r > DEPTH)
                    rs.status = ise_pkg::ST_FULL;
                else
                    splice(i, j, r, pl[0], ph[0], pl[1], ph[1]);
            end
        end
        else if (rq.req_type == ise_pkg::REQ_QUERY)
        begin
            for (k = 0; k < tbl_n; k++)
                if (tbl_lo[k] <= lo && tbl_hi[k] >= hi)
                    rs.covered = 1'b1;
        end
        rs.entry_count = tbl_n[ise_pkg::COUNT_W-1:0];
        return rs;
    endfunction

    // Drive one request and hold it until the transfer
    task automatic send_request(logic [ise_pkg::REQ_W-1:0] op, logic [63:0] lo,
                                logic [63:0] hi);
        ise_pkg::req_t rq;
        rq.req_type = op;
        rq.range_lo = lo;
        rq.range_hi = hi;
        while ($urandom_range(99) < idle_src_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= rq;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_rsp = {pending_rsp, predict_interval_op(rq)};
        sent_cnt++;
        @(negedge clk);
    endtask

    // Hold the sender idle until every expected response has come
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() > 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    // Random bound drawn mostly from a small window so intervals interact
    function automatic logic [63:0] pick_bound();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return {$urandom, $urandom};
        if (sel == 1)
            return ($urandom_range(1)) ? MAXV - $urandom_range(3) : MINV + $urandom_range(3);
        return 64'(signed'($urandom_range(400)) - 200);
    endfunction

    task automatic random_request(int bias_add);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        int pick;
        logic [ise_pkg::REQ_W-1:0] op;
        a = pick_bound();
        b = ($urandom_range(3) == 0) ? pick_bound() : a + 64'($urandom_range(12));
        if ($urandom_range(19) != 0 && $signed(a) > $signed(b))
        begin
            t = a; a = b; b = t;
        end
        pick = $urandom_range(99);
        if (pick < bias_add) op = ise_pkg::REQ_ADD;
        else if (pick < bias_add + (97 - bias_add) / 2) op = ise_pkg::REQ_REMOVE;
        else if (pick < 97) op = ise_pkg::REQ_QUERY;
        else op = ise_pkg::REQ_NONE;
        send_request(op, a, b);
    endtask

    // Directed: extremes, every operation, merge, split, invalid, unknown type
    task automatic test_directed();
        send_request(ise_pkg::REQ_REMOVE, 64'd0, 64'd5);
        send_request(ise_pkg::REQ_ADD, 64'd10, 64'd20);
        send_request(ise_pkg::REQ_ADD, 64'd21, 64'd30);
        send_request(ise_pkg::REQ_QUERY, 64'd10, 64'd30);
        send_request(ise_pkg::REQ_QUERY, 64'd15, 64'd15);
        send_request(ise_pkg::REQ_QUERY, 64'd9, 64'd15);
        send_request(ise_pkg::REQ_REMOVE, 64'd15, 64'd16);
        send_request(ise_pkg::REQ_QUERY, 64'd14, 64'd17);
        send_request(ise_pkg::REQ_ADD, 64'd5, 64'd4);
        send_request(ise_pkg::REQ_REMOVE, 64'd9, 64'd8);
        send_request(ise_pkg::REQ_QUERY, MAXV, MINV);
        send_request(ise_pkg::REQ_NONE, 64'd9, 64'd1);
        send_request(ise_pkg::REQ_ADD, MAXV, MAXV);
        send_request(ise_pkg::REQ_ADD, MINV, MINV);
        send_request(ise_pkg::REQ_ADD, MAXV - 64'd1, MAXV - 64'd1);
        send_request(ise_pkg::REQ_QUERY, MINV, MAXV);
        send_request(ise_pkg::REQ_ADD, MINV, MAXV);
        send_request(ise_pkg::REQ_QUERY, MINV, MAXV);
        send_request(ise_pkg::REQ_REMOVE, MINV, MAXV);
        send_request(ise_pkg::REQ_ADD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_request(ise_pkg::REQ_REMOVE, MINV, MAXV);
        drain_responses();
    endtask

    // Fill the table and hit the full limit on add and on split
    task automatic test_table_full();
        int k;
        for (k = 0; k < DEPTH + 1; k++)
            send_request(ise_pkg::REQ_ADD, 64'(k * 10), 64'(k * 10 + 4));
        send_request(ise_pkg::REQ_REMOVE, 64'd2, 64'd2);
        send_request(ise_pkg::REQ_REMOVE, 64'd0, 64'd4);
        send_request(ise_pkg::REQ_REMOVE, 64'd12, 64'd12);
        send_request(ise_pkg::REQ_REMOVE, MINV, MAXV);
        drain_responses();
    endtask

    task automatic test_random(int count, int src_pct, int rcv_pct);
        int k;
        idle_src_pct = src_pct;
        stall_rcv_pct = rcv_pct;
        for (k = 0; k < count; k++)
        begin
            random_request((tbl_n > 24) ? 30 : 55);
            if (k == count / 2)
                drain_responses();
        end
        drain_responses();
        send_request(ise_pkg::REQ_REMOVE, MINV, MAXV);
        drain_responses();
    endtask

    // Check each response against the oldest prediction
    always @(posedge clk)
    begin
        ise_pkg::rsp_t exp_rsp;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got_cnt++;
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                fail_cnt++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_ch.payload.covered !== exp_rsp.covered)
                begin
                    $error("covered: expected %0d actual %0d", exp_rsp.covered,
                           rsp_ch.payload.covered);
                    fail_cnt++;
                end
                if (rsp_ch.payload.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d actual %0d", exp_rsp.status,
                           rsp_ch.payload.status);
                    fail_cnt++;
                end
                if (rsp_ch.payload.entry_count !== exp_rsp.entry_count)
                begin
                    $error("entry_count: expected %0d actual %0d", exp_rsp.entry_count,
                           rsp_ch.payload.entry_count);
                    fail_cnt++;
                end
                if (exp_rsp.status == ise_pkg::ST_OK) ok_cnt++;
                else if (exp_rsp.status == ise_pkg::ST_FULL) full_cnt++;
                else inval_cnt++;
            end
        end
    end

    // Stall the response side at random
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_rcv_pct);

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WDOG_MAX)
        begin
            $display("timeout: no transfer for %0d cycles", WDOG_MAX);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b1;
        tbl_n = 0;
        fail_cnt = 0;
        sent_cnt = 0;
        got_cnt = 0;
        ok_cnt = 0;
        full_cnt = 0;
        inval_cnt = 0;
        idle_src_pct = 0;
        stall_rcv_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_table_full();
        test_random(120, 0, 0);
        test_random(120, 70, 0);
        test_random(120, 0, 70);
        test_random(120, 21, 21);
        $display("sent %0d requests, checked %0d responses", sent_cnt, got_cnt);
        $display("outcomes: %0d ok, %0d full, %0d invalid", ok_cnt, full_cnt, inval_cnt);
        if (fail_cnt == 0 && pending_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ise_pkg.sv
rtl/core/ise_req_if.sv
rtl/core/ise_rsp_if.sv
rtl/core/interval_set_engine_unit.sv
verif/interval_set_engine_unit_tb.sv
